// ===== rtl/core/jvas_pkg.sv =====
// ----------------------------------------------------------------------------
// jvas_pkg - shared types and constants
// Lane result word, limit codes, register indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none
package jvas_pkg;

	localparam int LANES = 4;

	// Q1.16 unity
	localparam logic [16:0] ONE_Q16 = 17'h10000;

	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_VEL  = 2'd1;
	localparam logic [1:0] KIND_ACC  = 2'd2;

	localparam logic [2:0] JOINT_NONE = 3'b111;

	localparam logic [1:0] REG_VEL_LIMITS = 2'd0;
	localparam logic [1:0] REG_ACC_LIMITS = 2'd1;
	localparam logic [1:0] REG_VEL_ENABLE = 2'd2;
	localparam logic [1:0] REG_ACC_ENABLE = 2'd3;

	localparam logic [63:0] VEL_LIMITS_RST = 64'h0100_0100_0100_0100;
	localparam logic [63:0] ACC_LIMITS_RST = 64'h0500_0500_0500_0500;

	// what one lane hands to the merge stage
	typedef struct packed {
		logic               vprop;
		logic [15:0]        vq;
		logic               aprop;
		logic [15:0]        aq;
		logic signed [15:0] v;
	} lane_res_t;

endpackage
`default_nettype wire

// ===== rtl/core/jvas_ifs.sv =====
// ----------------------------------------------------------------------------
// jvas channel interfaces
// Input word, result word and configuration write channel.
// ----------------------------------------------------------------------------
`default_nettype none
interface jvas_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] cmd_vel_0;
	logic signed [15:0] cmd_vel_1;
	logic signed [15:0] cmd_vel_2;
	logic signed [15:0] cmd_vel_3;
	logic signed [15:0] prev_vel_0;
	logic signed [15:0] prev_vel_1;
	logic signed [15:0] prev_vel_2;
	logic signed [15:0] prev_vel_3;
	logic [15:0]        time_step;
	logic               prev_valid;

	modport source (output valid, cmd_vel_0, cmd_vel_1, cmd_vel_2, cmd_vel_3,
		prev_vel_0, prev_vel_1, prev_vel_2, prev_vel_3, time_step, prev_valid,
		input ready);
	modport sink (input valid, cmd_vel_0, cmd_vel_1, cmd_vel_2, cmd_vel_3,
		prev_vel_0, prev_vel_1, prev_vel_2, prev_vel_3, time_step, prev_valid,
		output ready);
endinterface

interface jvas_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] out_vel_0;
	logic signed [15:0] out_vel_1;
	logic signed [15:0] out_vel_2;
	logic signed [15:0] out_vel_3;
	logic [16:0]        scale;
	logic [1:0]         limit_kind;
	logic signed [2:0]  lim_joint;

	modport source (output valid, out_vel_0, out_vel_1, out_vel_2, out_vel_3,
		scale, limit_kind, lim_joint, input ready);
	modport sink (input valid, out_vel_0, out_vel_1, out_vel_2, out_vel_3,
		scale, limit_kind, lim_joint, output ready);
endinterface

interface jvas_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [63:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/jvas_lane.sv =====
// ----------------------------------------------------------------------------
// jvas_lane - one joint
// Acceleration product, factor numerators, two 16-stage restoring dividers.
// ----------------------------------------------------------------------------
`default_nettype none
module jvas_lane (
	input  wire logic               clk,
	input  wire logic [17:0]        adv,
	input  wire logic signed [15:0] cmd_vel,
	input  wire logic signed [15:0] prev_vel,
	input  wire logic [15:0]        time_step,
	input  wire logic               prev_valid,
	input  wire logic [15:0]        vel_lim,
	input  wire logic [15:0]        acc_lim,
	input  wire logic               vel_en,
	input  wire logic               acc_en,
	output jvas_pkg::lane_res_t     res
);
	import jvas_pkg::*;

	// stage 1: amax * dt
	logic signed [15:0] v_s1, p_s1;
	logic [31:0]        step_s1;
	logic               aact_s1, ven_s1;

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			v_s1    <= cmd_vel;
			p_s1    <= prev_vel;
			step_s1 <= acc_lim * time_step;
			aact_s1 <= acc_en & (time_step != 16'd0) & prev_valid;
			ven_s1  <= vel_en;
		end
	end

	// stage 2: numerators and take-part flags
	logic [15:0]        va, pa;
	logic signed [16:0] dv;
	logic [16:0]        dva;
	logic signed [33:0] reach;
	logic [33:0]        ra, num;
	logic               exceed, rpos, a_ok, vprop_c, aprop_c;

	always_comb begin
		va     = v_s1[15] ? (~v_s1 + 16'd1) : v_s1;
		pa     = p_s1[15] ? (~p_s1 + 16'd1) : p_s1;
		dv     = {v_s1[15], v_s1} - {p_s1[15], p_s1};
		dva    = dv[16] ? (~dv + 17'd1) : dv;
		exceed = ({dva, 16'd0} > {1'b0, step_s1}) && (v_s1 != 16'sd0) && aact_s1;
		reach  = dv[16] ? ({{2{p_s1[15]}}, p_s1, 16'd0} - {2'd0, step_s1})
		                : ({{2{p_s1[15]}}, p_s1, 16'd0} + {2'd0, step_s1});
		ra     = reach[33] ? (~reach + 34'd1) : reach;
		rpos   = (reach != 34'sd0) && (reach[33] == v_s1[15]);
		num    = rpos ? ra : {2'd0, pa, 16'd0};
		// quotient of 1.0 or more never wins
		a_ok   = num < {2'd0, va, 16'd0};
		aprop_c = exceed && a_ok;
		vprop_c = ven_s1 && (va > vel_lim);
	end

	// divider pipeline, entry 0 is stage 2
	logic [15:0]        vrem_sd [0:16];
	logic [15:0]        vlow_sd [0:16];
	logic [15:0]        vq_sd   [0:16];
	logic [15:0]        arem_sd [0:16];
	logic [15:0]        alow_sd [0:16];
	logic [15:0]        aq_sd   [0:16];
	logic [15:0]        va_sd   [0:16];
	logic signed [15:0] v_sd    [0:16];
	logic               vp_sd   [0:16];
	logic               ap_sd   [0:16];

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			vrem_sd[0] <= vel_lim;
			vlow_sd[0] <= 16'd0;
			vq_sd[0]   <= 16'd0;
			arem_sd[0] <= num[31:16];
			alow_sd[0] <= num[15:0];
			aq_sd[0]   <= 16'd0;
			va_sd[0]   <= va;
			v_sd[0]    <= v_s1;
			vp_sd[0]   <= vprop_c;
			ap_sd[0]   <= aprop_c;
		end
	end

	for (genvar k = 0; k < 16; k++) begin : g_div
		logic [16:0] vt, at;
		logic        vge, age;

		always_comb begin
			vt  = {vrem_sd[k], vlow_sd[k][15]};
			at  = {arem_sd[k], alow_sd[k][15]};
			vge = vt >= {1'b0, va_sd[k]};
			age = at >= {1'b0, va_sd[k]};
		end

		always_ff @(posedge clk) begin
			if (adv[2+k]) begin
				vrem_sd[k+1] <= vge ? 16'(vt - {1'b0, va_sd[k]}) : vt[15:0];
				arem_sd[k+1] <= age ? 16'(at - {1'b0, va_sd[k]}) : at[15:0];
				vlow_sd[k+1] <= {vlow_sd[k][14:0], 1'b0};
				alow_sd[k+1] <= {alow_sd[k][14:0], 1'b0};
				vq_sd[k+1]   <= {vq_sd[k][14:0], vge};
				aq_sd[k+1]   <= {aq_sd[k][14:0], age};
				va_sd[k+1]   <= va_sd[k];
				v_sd[k+1]    <= v_sd[k];
				vp_sd[k+1]   <= vp_sd[k];
				ap_sd[k+1]   <= ap_sd[k];
			end
		end
	end

	assign res.vprop = vp_sd[16];
	assign res.vq    = vq_sd[16];
	assign res.aprop = ap_sd[16];
	assign res.aq    = aq_sd[16];
	assign res.v     = v_sd[16];

endmodule
`default_nettype wire

// ===== rtl/core/jvas_merge.sv =====
// ----------------------------------------------------------------------------
// jvas_merge - factor selection and scaling
// Lowest proposal per limit kind, lowest joint on ties, then cmd * factor.
// ----------------------------------------------------------------------------
`default_nettype none
module jvas_merge (
	input  wire logic                clk,
	input  wire logic [1:0]          adv,
	input  jvas_pkg::lane_res_t      res [jvas_pkg::LANES],
	output logic signed [15:0]       out_vel [jvas_pkg::LANES],
	output logic [16:0]              scale,
	output logic [1:0]               limit_kind,
	output logic [2:0]               lim_joint
);
	import jvas_pkg::*;

	logic [16:0] vmn, amn, sc_c;
	logic [2:0]  vj, aj, jt_c;
	logic [1:0]  kd_c;

	always_comb begin
		vmn = ONE_Q16;
		amn = ONE_Q16;
		vj  = JOINT_NONE;
		aj  = JOINT_NONE;
		for (int i = 0; i < LANES; i++) begin
			if (res[i].vprop && ({1'b0, res[i].vq} < vmn)) begin
				vmn = {1'b0, res[i].vq};
				vj  = 3'(i);
			end
			if (res[i].aprop && ({1'b0, res[i].aq} < amn)) begin
				amn = {1'b0, res[i].aq};
				aj  = 3'(i);
			end
		end
		sc_c = ONE_Q16;
		kd_c = KIND_NONE;
		jt_c = JOINT_NONE;
		if (vmn < sc_c) begin
			sc_c = vmn;
			kd_c = KIND_VEL;
			jt_c = vj;
		end
		if (amn < sc_c) begin
			sc_c = amn;
			kd_c = KIND_ACC;
			jt_c = aj;
		end
	end

	logic [16:0]        scale_s19;
	logic [1:0]         kind_s19;
	logic [2:0]         joint_s19;
	logic signed [15:0] v_s19 [LANES];

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			scale_s19 <= sc_c;
			kind_s19  <= kd_c;
			joint_s19 <= jt_c;
			for (int i = 0; i < LANES; i++) v_s19[i] <= res[i].v;
		end
	end

	// |v| * factor, truncated toward zero
	logic [15:0] mag  [LANES];
	logic [32:0] prod [LANES];

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			mag[i]  = v_s19[i][15] ? (~v_s19[i] + 16'd1) : v_s19[i];
			prod[i] = mag[i] * scale_s19;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			for (int i = 0; i < LANES; i++)
				out_vel[i] <= v_s19[i][15] ? (~prod[i][31:16] + 16'd1) : prod[i][31:16];
			scale      <= scale_s19;
			limit_kind <= kind_s19;
			lim_joint  <= joint_s19;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/joint_velocity_accel_scaler_core.sv =====
// ----------------------------------------------------------------------------
// joint_velocity_accel_scaler_core - common-factor joint speed limiter
// Velocity and acceleration limits give one Q1.16 factor for all joints.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                       | accept
//  din     | in  | cmd_vel_0..3, prev_vel_0..3, time_step, flag  | valid & ready
//  dout    | out | out_vel_0..3, scale, limit_kind, joint        | valid & ready
//  cfg     | in  | index (2b), data (64b)                        | valid & ready
//
//  One word per cycle sustained while dout takes results; the pipe is
//  the product and prep stages, the two 16-stage restoring dividers in
//  each joint lane, then the select and scale stages.
//  Every stage moves when it is empty or the next one moves, so bubbles
//  close up and din keeps taking words while a result waits on dout, until every stage is full.
//  Reset clears the stage valid bits and loads the register reset values.
//  cfg is always ready; writes are expected only while the pipe is empty.
// ----------------------------------------------------------------------------
`default_nettype none
module joint_velocity_accel_scaler_core #(
	parameter int JOINT_COUNT = 4
) (
	input wire logic  clk,
	input wire logic  arst_n,
	jvas_in_if.sink   din,
	jvas_out_if.source dout,
	jvas_cfg_if.sink  cfg
);
	import jvas_pkg::*;

	localparam int NS = 20;

	// configuration
	logic [63:0] vel_lim_q, acc_lim_q;
	logic        vel_en_q, acc_en_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vel_lim_q <= VEL_LIMITS_RST;
			acc_lim_q <= ACC_LIMITS_RST;
			vel_en_q  <= 1'b1;
			acc_en_q  <= 1'b1;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_VEL_LIMITS: vel_lim_q <= cfg.data;
				REG_ACC_LIMITS: acc_lim_q <= cfg.data;
				REG_VEL_ENABLE: vel_en_q  <= cfg.data[0];
				REG_ACC_ENABLE: acc_en_q  <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// stage occupancy and advance chain
	logic [NS-1:0] vld_q;
	logic [NS:0]   adv;

	assign adv[NS] = dout.ready;
	for (genvar k = 0; k < NS; k++) begin : g_adv
		assign adv[k] = ~vld_q[k] | adv[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) vld_q[0] <= din.valid;
			for (int k = 1; k < NS; k++) begin
				if (adv[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	assign din.ready  = adv[0];
	assign dout.valid = vld_q[NS-1];

	// joint lanes
	logic signed [15:0] cmd  [LANES];
	logic signed [15:0] prev [LANES];
	lane_res_t          res  [LANES];

	assign cmd[0]  = din.cmd_vel_0;
	assign cmd[1]  = din.cmd_vel_1;
	assign cmd[2]  = din.cmd_vel_2;
	assign cmd[3]  = din.cmd_vel_3;
	assign prev[0] = din.prev_vel_0;
	assign prev[1] = din.prev_vel_1;
	assign prev[2] = din.prev_vel_2;
	assign prev[3] = din.prev_vel_3;

	for (genvar j = 0; j < LANES; j++) begin : g_lane
		if (j < JOINT_COUNT) begin : g_on
			jvas_lane u_lane (
				.clk        (clk),
				.adv        (adv[17:0]),
				.cmd_vel    (cmd[j]),
				.prev_vel   (prev[j]),
				.time_step  (din.time_step),
				.prev_valid (din.prev_valid),
				.vel_lim    (vel_lim_q[16*j +: 16]),
				.acc_lim    (acc_lim_q[16*j +: 16]),
				.vel_en     (vel_en_q),
				.acc_en     (acc_en_q),
				.res        (res[j])
			);
		end else begin : g_off
			// absent joint: never limits, output 0
			assign res[j] = '0;
		end
	end

	logic signed [15:0] ovel [LANES];

	jvas_merge u_merge (
		.clk        (clk),
		.adv        (adv[19:18]),
		.res        (res),
		.out_vel    (ovel),
		.scale      (dout.scale),
		.limit_kind (dout.limit_kind),
		.lim_joint  (dout.lim_joint)
	);

	assign dout.out_vel_0 = ovel[0];
	assign dout.out_vel_1 = ovel[1];
	assign dout.out_vel_2 = ovel[2];
	assign dout.out_vel_3 = ovel[3];

	// checks
	a_full_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!din.ready |-> (&vld_q))
		else $error("input stalled with a free stage");

	a_scale_range: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid |-> (dout.scale <= ONE_Q16))
		else $error("factor above unity");

	a_none_is_unity: assert property (@(posedge clk) disable iff (!arst_n)
		(dout.valid && dout.limit_kind == KIND_NONE) |->
		(dout.scale == ONE_Q16 && dout.lim_joint == JOINT_NONE))
		else $error("no limit but factor or joint set");

	a_joint_exists: assert property (@(posedge clk) disable iff (!arst_n)
		(dout.valid && dout.limit_kind != KIND_NONE) |->
		(dout.scale < ONE_Q16 && {29'd0, dout.lim_joint} < JOINT_COUNT))
		else $error("limiting joint out of range");

endmodule
`default_nettype wire
